@@ rtl/q2e_pkg.sv @@
// Package for the quaternion to Euler angle converter.
// Types, fixed-point constants and the CORDIC arctangent table; no dependencies.
package q2e_pkg;

    localparam int SQRT_STAGES = 31;   // one result bit per stage, 2^60 down to 2^0
    localparam int DW          = 40;   // width of the product-term datapath
    localparam int CW          = 44;   // CORDIC x/y width
    localparam int ZW          = 35;   // CORDIC angle width, Q.30

    localparam logic signed [DW-1:0] ONE_Q30    = 40'sd1073741824;
    localparam logic signed [DW-1:0] THRESH_Q30 = 40'sd536763538;
    localparam logic signed [ZW-1:0] PI_Q30     = 35'sd3373259426;
    localparam logic signed [31:0]   HALF_PI_Q28 = 32'sd421657428;
    localparam logic [63:0]          ONE_Q60    = 64'd1 << 60;

    typedef enum logic [1:0] {
        SC_NORMAL = 2'd0,
        SC_NORTH  = 2'd1,
        SC_SOUTH  = 2'd2
    } t_sc;

    // Terms that travel alongside the square root
    typedef struct packed {
        logic signed [DW-1:0] hy;
        logic signed [DW-1:0] hx;
        logic signed [DW-1:0] ry;
        logic signed [DW-1:0] rx;
        logic signed [31:0]   s;
        t_sc                  sc;
    } t_side;

    // round(atan(2^-i) * 2^30)
    function automatic logic [29:0] atan_q30(input int i);
        logic [29:0] v;
        case (i)
            0:  v = 30'd843314857;
            1:  v = 30'd497837829;
            2:  v = 30'd263043837;
            3:  v = 30'd133525159;
            4:  v = 30'd67021687;
            5:  v = 30'd33543516;
            6:  v = 30'd16775851;
            7:  v = 30'd8388437;
            8:  v = 30'd4194283;
            9:  v = 30'd2097149;
            default: v = (i < 31) ? 30'(64'd1 << (30 - i)) : 30'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/q2e_if.sv @@
// Handshake channels of the quaternion to Euler converter.
// Depends on nothing; payload widths are fixed by the field formats.
interface q2e_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic signed [31:0] qw;
    modport source (output valid, qx, qy, qz, qw, input ready);
    modport sink   (input valid, qx, qy, qz, qw, output ready);
endinterface

interface q2e_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] heading;
    logic [1:0]         singular_case;
    modport source (output valid, roll, pitch, heading, singular_case, input ready);
    modport sink   (input valid, roll, pitch, heading, singular_case, output ready);
endinterface

@@ rtl/quaternion_to_euler.sv @@
// Top level: quaternion (Q2.30) to roll, pitch, heading (Q3.28) with gimbal-lock case.
// Depends on q2e_pkg, q2e_if, q2e_isqrt and q2e_cordic.
//
//  channel | dir | payload                                  | handshake
//  i_in    | in  | qx, qy, qz, qw                           | valid / ready
//  o_out   | out | roll, pitch, heading, singular_case      | valid / ready
//
// One transaction per cycle unless the output register is full and not taken; stages in
// order: products, terms, square, remainder, 31 square-root stages, CORDIC, output register.
// The square root and the CORDIC chains set the depth.
// Synchronous active-low reset clears the valid bits only.
// The whole pipeline holds while the output register is full and not taken.
module quaternion_to_euler #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    q2e_in_if.sink    i_in,
    q2e_out_if.source o_out
);
    import q2e_pkg::*;

    localparam int NS   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int LATC = 4 + SQRT_STAGES + NS + 1;

    logic en;
    logic r_ov;
    logic r_vld [0:LATC-1];

    assign en         = !r_ov || o_out.ready;
    assign i_in.ready = en;

    // stage A: products
    logic signed [63:0] r_yz, r_xw, r_zw, r_yx, r_zz, r_xx, r_yw, r_zx, r_yy;
    logic signed [31:0] r_a_y, r_a_w;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yz  <= i_in.qy * i_in.qz;
            r_xw  <= i_in.qx * i_in.qw;
            r_zw  <= i_in.qz * i_in.qw;
            r_yx  <= i_in.qy * i_in.qx;
            r_zz  <= i_in.qz * i_in.qz;
            r_xx  <= i_in.qx * i_in.qx;
            r_yw  <= i_in.qy * i_in.qw;
            r_zx  <= i_in.qz * i_in.qx;
            r_yy  <= i_in.qy * i_in.qy;
            r_a_y <= i_in.qy;
            r_a_w <= i_in.qw;
        end
    end

    // stage B: test term and atan2 operands
    logic signed [DW-1:0] r_test, r_hn, r_hd, r_rn, r_rd;
    logic signed [31:0]   r_b_y, r_b_w;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_test <= DW'(r_yz >>> 30) + DW'(r_xw >>> 30);
            r_hn   <= DW'(r_zw >>> 29) - DW'(r_yx >>> 29);
            r_hd   <= ONE_Q30 - DW'(r_zz >>> 29) - DW'(r_xx >>> 29);
            r_rn   <= DW'(r_yw >>> 29) - DW'(r_zx >>> 29);
            r_rd   <= ONE_Q30 - DW'(r_yy >>> 29) - DW'(r_xx >>> 29);
            r_b_y  <= r_a_y;
            r_b_w  <= r_a_w;
        end
    end

    // stage C: case decision, s squared, heading operand select
    t_side              n_c_side, r_c_side;
    logic signed [31:0] s32;
    logic signed [63:0] r_c_sq;
    always_comb begin
        s32          = 32'(r_test <<< 1);
        n_c_side.s   = s32;
        n_c_side.ry  = r_rn;
        n_c_side.rx  = r_rd;
        if (r_test > THRESH_Q30) begin
            n_c_side.sc = SC_NORTH;
        end else if (r_test < -THRESH_Q30) begin
            n_c_side.sc = SC_SOUTH;
        end else begin
            n_c_side.sc = SC_NORMAL;
        end
        if (n_c_side.sc != SC_NORMAL) begin
            n_c_side.hy = DW'(r_b_y);
            n_c_side.hx = DW'(r_b_w);
        end else begin
            n_c_side.hy = r_hn;
            n_c_side.hx = r_hd;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_side <= n_c_side;
            r_c_sq   <= s32 * s32;
        end
    end

    // stage D and the square-root span: side terms ride along
    t_side       r_sd [0:SQRT_STAGES];
    logic [60:0] r_rem;
    logic [30:0] root;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem   <= 61'(ONE_Q60 - $unsigned(r_c_sq));
            r_sd[0] <= r_c_side;
            for (int k = 1; k <= SQRT_STAGES; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    q2e_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_v    (r_rem),
        .o_root (root)
    );

    // three CORDIC chains in parallel
    t_side                side_q;
    logic signed [ZW-1:0] hz, rz, pz;
    assign side_q = r_sd[SQRT_STAGES];

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_head (
        .i_clk (i_clk), .i_en (en),
        .i_y   (CW'(side_q.hy)), .i_x (CW'(side_q.hx)), .o_z (hz)
    );
    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .i_clk (i_clk), .i_en (en),
        .i_y   (CW'(side_q.ry)), .i_x (CW'(side_q.rx)), .o_z (rz)
    );
    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk (i_clk), .i_en (en),
        .i_y   (CW'(side_q.s)), .i_x ($signed(CW'({1'b0, root}))), .o_z (pz)
    );

    t_sc r_sc [0:NS];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sc[0] <= side_q.sc;
            for (int k = 1; k <= NS; k++) begin
                r_sc[k] <= r_sc[k-1];
            end
        end
    end

    // output register
    logic signed [ZW:0]  hz_r, rz_r, pz_r, hz_h;
    logic signed [31:0]  n_roll, n_pitch, n_head;
    logic signed [31:0]  r_roll, r_pitch, r_head;
    t_sc                 r_osc;
    always_comb begin
        hz_r = (ZW+1)'(hz) + (ZW+1)'(2);
        rz_r = (ZW+1)'(rz) + (ZW+1)'(2);
        pz_r = (ZW+1)'(pz) + (ZW+1)'(2);
        hz_h = (ZW+1)'(hz) + (ZW+1)'(1);
        unique case (r_sc[NS])
            SC_NORTH, SC_SOUTH: begin
                n_roll  = '0;
                n_pitch = (r_sc[NS] == SC_NORTH) ? HALF_PI_Q28 : -HALF_PI_Q28;
                n_head  = 32'(hz_h >>> 1);
            end
            default: begin
                n_roll  = 32'(rz_r >>> 2);
                n_pitch = 32'(pz_r >>> 2);
                n_head  = 32'(hz_r >>> 2);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            for (int k = 0; k < LATC; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k < LATC; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_ov <= r_vld[LATC-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll  <= n_roll;
            r_pitch <= n_pitch;
            r_head  <= n_head;
            r_osc   <= r_sc[NS];
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.roll          = r_roll;
    assign o_out.pitch         = r_pitch;
    assign o_out.heading       = r_head;
    assign o_out.singular_case = r_osc;

endmodule

@@ rtl/q2e_isqrt.sv @@
// Pipelined floor square root of a 61-bit value, one result bit per stage.
// Depends on q2e_pkg.
module q2e_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [60:0] i_v,
    output logic [30:0] o_root
);
    import q2e_pkg::*;

    logic [60:0] r_v [1:SQRT_STAGES];
    logic [61:0] r_r [1:SQRT_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
            localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
            logic [60:0] v_in;
            logic [61:0] r_in;
            logic [61:0] trial;
            logic [60:0] n_v;
            logic [61:0] n_r;
            if (k == 0) begin : g_first
                assign v_in = i_v;
                assign r_in = '0;
            end else begin : g_next
                assign v_in = r_v[k];
                assign r_in = r_r[k];
            end
            always_comb begin
                trial = r_in + BIT;
                if ({1'b0, v_in} >= trial) begin
                    n_v = 61'({1'b0, v_in} - trial);
                    n_r = (r_in >> 1) + BIT;
                end else begin
                    n_v = v_in;
                    n_r = r_in >> 1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[k+1] <= n_v;
                    r_r[k+1] <= n_r;
                end
            end
        end
    endgenerate

    assign o_root = r_r[SQRT_STAGES][30:0];

endmodule

@@ rtl/q2e_cordic.sv @@
// Pipelined vectoring CORDIC: atan2(y, x) in Q.30, one micro-rotation per stage.
// Depends on q2e_pkg. An input register precedes the micro-rotation stages.
module q2e_cordic #(
    parameter int STEPS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [q2e_pkg::CW-1:0] i_y,
    input  logic signed [q2e_pkg::CW-1:0] i_x,
    output logic signed [q2e_pkg::ZW-1:0] o_z
);
    import q2e_pkg::*;

    localparam int NS = (STEPS > 32) ? 32 : STEPS;

    logic signed [CW-1:0] r_x [0:NS];
    logic signed [CW-1:0] r_y [0:NS];
    logic signed [ZW-1:0] r_z [0:NS];
    logic                 r_h [0:NS];   // angle settled by an axis case

    logic signed [CW-1:0] n_x0, n_y0;
    logic signed [ZW-1:0] n_z0;
    logic                 n_h0;

    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        n_z0 = '0;
        n_h0 = 1'b0;
        if (i_y == '0) begin
            n_h0 = 1'b1;
            n_z0 = (i_x < 0) ? PI_Q30 : '0;
        end else if (i_x < 0) begin
            n_x0 = -i_x;
            n_y0 = -i_y;
            n_z0 = (i_y > 0) ? PI_Q30 : -PI_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_z[0] <= n_z0;
            r_h[0] <= n_h0;
        end
    end

    genvar i;
    generate
        for (i = 0; i < NS; i++) begin : g_rot
            localparam logic signed [ZW-1:0] ANG = ZW'({5'b0, atan_q30(i)});
            logic signed [CW-1:0] xs, ys, n_x, n_y;
            logic signed [ZW-1:0] n_z;
            always_comb begin
                xs = r_x[i] >>> i;
                ys = r_y[i] >>> i;
                n_x = r_x[i];
                n_y = r_y[i];
                n_z = r_z[i];
                if (!r_h[i]) begin
                    if (r_y[i] >= 0) begin
                        n_x = r_x[i] + ys;
                        n_y = r_y[i] - xs;
                        n_z = r_z[i] + ANG;
                    end else begin
                        n_x = r_x[i] - ys;
                        n_y = r_y[i] + xs;
                        n_z = r_z[i] - ANG;
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[i+1] <= n_x;
                    r_y[i+1] <= n_y;
                    r_z[i+1] <= n_z;
                    r_h[i+1] <= r_h[i];
                end
            end
        end
    endgenerate

    assign o_z = r_z[NS];

endmodule

@@ rtl/q2e_chk.sv @@
// Port-level checker for quaternion_to_euler, attached by bind.
// Depends on q2e_pkg.
module q2e_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] i_roll,
    input logic signed [31:0] i_pitch,
    input logic [1:0]         i_singular_case
);
    import q2e_pkg::*;

    // input side only blocks behind a stalled result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without output back-pressure");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_singular_case != 2'd3))
        else $error("undefined singular case code");

    a_lock_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_singular_case != SC_NORMAL) |-> (i_roll == '0))
        else $error("nonzero roll in lock case");

    a_lock_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_singular_case == SC_NORTH) |-> (i_pitch == HALF_PI_Q28))
        else $error("north lock pitch not +pi/2");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_roll) && $stable(i_pitch)))
        else $error("stalled result changed");

endmodule

bind quaternion_to_euler q2e_chk u_q2e_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_roll          (o_out.roll),
    .i_pitch         (o_out.pitch),
    .i_singular_case (o_out.singular_case)
);

@@ bench/q2e_checker.sv @@
// Checker for the quaternion to Euler converter: watches both channels,
// predicts roll, pitch, heading and lock case, compares in order.
// Depends on q2e_pkg and q2e_if.
`timescale 1ns / 100ps

module q2e_checker #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    q2e_in_if      i_in,
    q2e_out_if     o_out,
    output int     o_errors,
    output int     o_pending
);
    import q2e_pkg::*;

    typedef struct packed {
        logic signed [31:0] roll;
        logic signed [31:0] pitch;
        logic signed [31:0] heading;
        t_sc                sc;
    } t_angles;

    localparam longint PI30    = 64'sd3373259426;
    localparam longint THRESH  = 64'sd536763538;
    localparam longint HALFPI  = 64'sd421657428;

    t_angles angles_due[$];

    function automatic longint atan_step(int i);
        longint tab [10];
        tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
                33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10) return tab[i];
        if (i < 31) return longint'(1) << (30 - i);
        return 0;
    endfunction

    function automatic longint vec_angle(longint vy, longint vx);
        longint ang, nx, xs, ys;
        int n;
        ang = 0;
        n = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
        if (vy == 0) return (vx < 0) ? PI30 : 0;
        if (vx < 0) begin
            ang = (vy > 0) ? PI30 : -PI30;
            vx = -vx;
            vy = -vy;
        end
        for (int i = 0; i < n; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy >= 0) begin
                vx += ys; vy -= xs; ang += atan_step(i);
            end else begin
                vx -= ys; vy += xs; ang -= atan_step(i);
            end
        end
        return ang;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic logic signed [31:0] to_q28(longint a);
        longint r;
        r = (a + 2) >>> 2;
        return r[31:0];
    endfunction

    function automatic t_angles euler_of(longint x, longint y, longint z, longint w);
        t_angles e;
        longint t, hn, hd, rn, rd, s, c;
        longint h;
        t = ((y * z) >>> 30) + ((x * w) >>> 30);
        if (t > THRESH || t < -THRESH) begin
            e.sc      = (t > 0) ? SC_NORTH : SC_SOUTH;
            h         = (vec_angle(y, w) + 1) >>> 1;
            e.heading = h[31:0];
            e.pitch   = (e.sc == SC_NORTH) ? HALFPI[31:0] : -HALFPI[31:0];
            e.roll    = '0;
        end else begin
            hn = ((z * w) >>> 29) - ((y * x) >>> 29);
            hd = 64'sd1073741824 - ((z * z) >>> 29) - ((x * x) >>> 29);
            rn = ((y * w) >>> 29) - ((z * x) >>> 29);
            rd = 64'sd1073741824 - ((y * y) >>> 29) - ((x * x) >>> 29);
            s  = 2 * t;
            c  = floor_sqrt((64'd1 << 60) - longint'(s * s));
            e.sc      = SC_NORMAL;
            e.heading = to_q28(vec_angle(hn, hd));
            e.roll    = to_q28(vec_angle(rn, rd));
            e.pitch   = to_q28(vec_angle(s, c));
        end
        return e;
    endfunction

    always @(posedge i_clk) begin
        t_angles e;
        if (!i_rst_n) begin
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_in.valid && i_in.ready)
                angles_due = {angles_due, euler_of(i_in.qx, i_in.qy, i_in.qz, i_in.qw)};
            if (o_out.valid && o_out.ready) begin
                if (angles_due.size() == 0) begin
                    $error("result with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    e = angles_due.pop_front();
                    if (o_out.roll !== e.roll || o_out.pitch !== e.pitch ||
                        o_out.heading !== e.heading || o_out.singular_case !== e.sc)
                        o_errors <= o_errors + 1;
                    if (o_out.roll !== e.roll)
                        $error("roll: expected %0d, got %0d", e.roll, o_out.roll);
                    if (o_out.pitch !== e.pitch)
                        $error("pitch: expected %0d, got %0d", e.pitch, o_out.pitch);
                    if (o_out.heading !== e.heading)
                        $error("heading: expected %0d, got %0d", e.heading, o_out.heading);
                    if (o_out.singular_case !== e.sc)
                        $error("singular_case: expected %0d, got %0d",
                               e.sc, o_out.singular_case);
                end
            end
            o_pending <= angles_due.size();
        end
    end

endmodule

@@ bench/tb.sv @@
// Testbench top: drives quaternions into the converter with random gaps and
// output stalls, then gives the verdict. Depends on q2e_pkg, q2e_if, q2e_checker.
`timescale 1ns / 100ps

module tb;
    import q2e_pkg::*;

    localparam int STEPS   = 24;
    localparam int LATENCY = STEPS + 37;
    localparam int N_RAND  = 1450;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending;
    int   rx_wait;
    bit   stall_on = 1'b0;

    q2e_in_if  qin ();
    q2e_out_if qout ();

    quaternion_to_euler #(.CORDIC_STEPS(STEPS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(qin), .o_out(qout));

    q2e_checker #(.CORDIC_STEPS(STEPS)) chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(qin), .o_out(qout),
        .o_errors(errors), .o_pending(pending));

    always #2 i_clk = ~i_clk;

    initial begin
        qin.valid = 1'b0;
        qin.qx = '0; qin.qy = '0; qin.qz = '0; qin.qw = '0;
        qout.ready = 1'b0;
    end

    // receiver: random per-transaction wait while stalls are on, with stretches of none
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            qout.ready <= 1'b0;
            rx_wait    <= 0;
        end else if (qout.valid && qout.ready) begin
            w = stall_on ? $urandom_range(0, 18) : 0;
            qout.ready <= (w == 0);
            rx_wait    <= (w == 0) ? 0 : w - 1;
        end else if (rx_wait != 0) begin
            qout.ready <= 1'b0;
            rx_wait    <= rx_wait - 1;
        end else begin
            qout.ready <= 1'b1;
        end
    end

    task automatic send(logic signed [31:0] x, y, z, w);
        int gap;
        gap = stall_on ? $urandom_range(0, 18) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            qin.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        qin.valid <= 1'b1;
        qin.qx <= x; qin.qy <= y; qin.qz <= z; qin.qw <= w;
        do @(posedge i_clk); while (!qin.ready);
    endtask

    // random unit-ish quaternion in Q2.30, optionally pushed toward a pole
    task automatic send_random();
        logic signed [31:0] v [4];
        int kind;
        int a;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 4; k++)
            v[k] = $signed($urandom_range(0, 32'h7fffffff)) - 32'sh40000000;
        if (kind == 0) begin
            for (int k = 0; k < 4; k++) v[k] = $urandom;
        end else if (kind <= 2) begin
            // y*z + x*w near +-0.5
            a = $urandom_range(32'h2d000000, 32'h2e000000);
            v[1] = ($urandom_range(0, 1) == 0) ? a : -a;
            v[2] = a + $signed($urandom_range(0, 32'h0400000)) - 32'sh200000;
            v[0] = $signed($urandom_range(0, 32'h01000000)) - 32'sh800000;
            v[3] = $signed($urandom_range(0, 32'h01000000)) - 32'sh800000;
        end else if (kind == 3) begin
            for (int k = 0; k < 4; k++) v[k] = v[k] >>> $urandom_range(0, 20);
        end else begin
            for (int k = 0; k < 4; k++) v[k] = v[k] >>> 1;
        end
        send(v[0], v[1], v[2], v[3]);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // extremes, zero vector, exact poles, negative-x and zero-y angles
        send(0, 0, 0, 0);
        send(0, 0, 0, 32'sh40000000);
        send(0, 0, 0, 32'sh80000000);
        send(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        send(32'sh2d413ccd, 0, 0, 32'sh2d413ccd);
        send(32'sh2d413ccd, 0, 0, -32'sh2d413ccd);
        send(0, 32'sh2d413ccd, 32'sh2d413ccd, 0);
        send(0, 32'sh2d413ccd, -32'sh2d413ccd, 0);
        send(32'sh40000000, 0, 0, 0);
        send(0, 32'sh40000000, 0, 0);
        send(0, 0, 32'sh40000000, 0);
        send(0, 32'sh20000000, 32'sh20000000, -32'sh40000000);
        send(0, -32'sh20000000, 32'sh20000000, -32'sh40000000);
        // test term just below the threshold in magnitude, with both signs
        send(0, 32'sh40000000, 32'sh1ffe2ce2, 0);
        send(0, 32'sh40000000, 32'sh1ffe2ce3, 0);
        send(0, 32'sh40000000, -32'sh1ffe2ce3, 0);
        send(32'sh00000001, 32'sh00000001, 32'sh00000001, 32'sh00000001);
        send(32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff);
        stall_on = 1'b1;
        for (int n = 0; n < N_RAND; n++) begin
            if (n == N_RAND / 2) begin
                // drain fully before resuming
                qin.valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
                stall_on = 1'b0;
            end
            if (n == N_RAND / 2 + 200) stall_on = 1'b1;
            send_random();
        end
        qin.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
